// ===== rtl/ltd_pkg.sv =====
package ltd_pkg;

  // transponder count must be a power of two so the id splits by bit slicing
  localparam int TRANSPONDERS = 16;
  localparam int IDX_BITS     = $clog2(TRANSPONDERS);
  localparam int STAMP_BITS   = 24;

  localparam int ID_BITS      = 8;
  localparam int TS_BITS      = 24;
  localparam int WHO_BITS     = 4;
  localparam int VALUE_BITS   = 24;
  localparam int KIND_BITS    = 2;
  localparam int RETRY_BITS   = 8;

  // stamps wider than the timestamp field never carry extra bits
  localparam int STORE_BITS   = (STAMP_BITS < TS_BITS) ? STAMP_BITS : TS_BITS;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LAP   = 2'd0,
    KIND_RETRY = 2'd1,
    KIND_POWER = 2'd2
  } kind_t;

  typedef struct packed {
    logic                length_ok;
    logic [ID_BITS-1:0]  packet_id;
    logic [TS_BITS-1:0]  timestamp;
  } packet_t;

  typedef struct packed {
    kind_t                  event_kind;
    logic [WHO_BITS-1:0]    transponder;
    logic [VALUE_BITS-1:0]  event_value;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

// ===== rtl/lap_time_event_decoder_top.sv =====
// Lap time event decoder: turns received transponder packets into events.
// Input channel (in_valid / in_stall): one packet per beat with length flag,
// packet id (kind in the upper bits, transponder in the low four) and stamp.
// Output channel (out_valid / out_stall): one event per beat with kind,
// transponder and value (lap duration, retry count or zero for power-up).
// A packet gives at most one event; bad length, first lap of a transponder,
// repeated stamp and unknown kinds give none.
// An accepted packet waits in the input register; its event is then loaded
// into the result register, which drives the output.
// Throughput is one packet per cycle unless a packet with an event meets a
// held result register: the per-transponder table is read, subtracted from
// and written between the input register and the result register.
// Reset clears all seen flags, so every transponder starts unarmed; stored
// stamps are only read once armed.
// When the receiver stalls, the held event stays put; a packet that needs
// the result register waits in the input register and in_stall rises, while
// packets that give no event still drain.
module lap_time_event_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_length_ok,
  input  logic [ltd_pkg::ID_BITS-1:0]       in_packet_id,
  input  logic [ltd_pkg::TS_BITS-1:0]       in_timestamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ltd_pkg::KIND_BITS-1:0]     out_event_kind,
  output logic [ltd_pkg::WHO_BITS-1:0]      out_transponder,
  output logic [ltd_pkg::VALUE_BITS-1:0]    out_event_value
);
  import ltd_pkg::*;

  packet_t    in_pkt;
  packet_t    pkt;
  logic       pkt_valid;
  stage_ctl_t ctl;
  logic       hit;
  logic       free;
  result_t    res;
  result_t    out_res;

  assign in_pkt.length_ok = in_length_ok;
  assign in_pkt.packet_id = in_packet_id;
  assign in_pkt.timestamp = in_timestamp;

  // a packet moves on unless it has an event and the result register is held
  assign ctl.valid   = pkt_valid;
  assign ctl.advance = pkt_valid && (!hit || free);

  ltd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pkt    (in_pkt),
    .advance   (ctl.advance),
    .pkt       (pkt),
    .pkt_valid (pkt_valid)
  );

  ltd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .pkt   (pkt),
    .ctl   (ctl),
    .hit   (hit),
    .res   (res)
  );

  ltd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.advance && hit),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_event_kind  = out_res.event_kind;
  assign out_transponder = out_res.transponder;
  assign out_event_value = out_res.event_value;

endmodule

// ===== rtl/ltd_in_stage.sv =====
module ltd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ltd_pkg::packet_t in_pkt,
  input  logic             advance,
  output ltd_pkg::packet_t pkt,
  output logic             pkt_valid
);
  import ltd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  packet_t pkt_r;
  logic    accept;

  assign in_stall  = valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign pkt       = pkt_r;
  assign pkt_valid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pkt_r <= in_pkt;
    end
  end

endmodule

// ===== rtl/ltd_core.sv =====
module ltd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  ltd_pkg::packet_t    pkt,
  input  ltd_pkg::stage_ctl_t ctl,
  output logic                hit,
  output ltd_pkg::result_t    res
);
  import ltd_pkg::*;

  logic [TRANSPONDERS-1:0] seen_r;
  logic [TRANSPONDERS-1:0] seen_nxt;
  logic [STORE_BITS-1:0]   stamp_r [TRANSPONDERS];

  logic [IDX_BITS-1:0]         idx;
  logic [ID_BITS-IDX_BITS-1:0] kind;
  logic [STORE_BITS-1:0]       ts;
  logic [STORE_BITS-1:0]       diff;
  logic                        is_lap;
  logic                        store;

  assign idx    = pkt.packet_id[IDX_BITS-1:0];
  assign kind   = pkt.packet_id[ID_BITS-1:IDX_BITS];
  assign ts     = pkt.timestamp[STORE_BITS-1:0];
  assign diff   = ts - stamp_r[idx];
  assign is_lap = pkt.length_ok && (kind == (ID_BITS-IDX_BITS)'(KIND_LAP));
  assign store  = ctl.valid && ctl.advance && is_lap;

  always_comb begin
    hit             = 1'b0;
    res.event_kind  = KIND_LAP;
    res.transponder = WHO_BITS'(idx);
    res.event_value = '0;
    if (pkt.length_ok) begin
      if (kind == (ID_BITS-IDX_BITS)'(KIND_LAP)) begin
        // first crossing only arms the transponder
        hit             = seen_r[idx] && (diff != '0);
        res.event_value = VALUE_BITS'(diff);
      end else if (kind == (ID_BITS-IDX_BITS)'(KIND_RETRY)) begin
        hit             = 1'b1;
        res.event_kind  = KIND_RETRY;
        res.event_value = VALUE_BITS'(pkt.timestamp[RETRY_BITS-1:0]);
      end else if (kind == (ID_BITS-IDX_BITS)'(KIND_POWER)) begin
        hit             = 1'b1;
        res.event_kind  = KIND_POWER;
      end
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (store) begin
      seen_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      stamp_r[idx] <= ts;
    end
  end

endmodule

// ===== rtl/ltd_out_stage.sv =====
module ltd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ltd_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output ltd_pkg::result_t out_res
);
  import ltd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/ltd_checker.sv =====
module ltd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ltd_pkg::KIND_BITS-1:0]  out_event_kind,
  input logic [ltd_pkg::WHO_BITS-1:0]   out_transponder,
  input logic [ltd_pkg::VALUE_BITS-1:0] out_event_value
);
  import ltd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind)
      && $stable(out_transponder) && $stable(out_event_value))
    else $error("stalled event changed");

  a_lap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_LAP) |-> (out_event_value != '0))
    else $error("lap event with zero duration");

  a_retry_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_RETRY)
      |-> (out_event_value[VALUE_BITS-1:RETRY_BITS] == '0))
    else $error("retry count wider than a byte");

  a_power_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_POWER) |-> (out_event_value == '0))
    else $error("power-up event with nonzero value");

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind == KIND_LAP) || (out_event_kind == KIND_RETRY)
      || (out_event_kind == KIND_POWER))
    else $error("event of unknown kind");

endmodule

bind lap_time_event_decoder_top ltd_checker u_ltd_checker (.*);

// ===== tb/lap_event_monitor.sv =====
module lap_event_monitor
  import ltd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   in_length_ok,
  input  logic [ID_BITS-1:0]     in_packet_id,
  input  logic [TS_BITS-1:0]     in_timestamp,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [KIND_BITS-1:0]   out_event_kind,
  input  logic [WHO_BITS-1:0]    out_transponder,
  input  logic [VALUE_BITS-1:0]  out_event_value,
  output int                     mismatch_count,
  output int                     pending,
  output int                     events_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TS_BITS-1:0] STAMP_MASK = {TS_BITS{1'b1}} >> (TS_BITS - STORE_BITS);

  bit                 armed       [TRANSPONDERS];
  logic [TS_BITS-1:0] stamp_store [TRANSPONDERS];
  result_t            expected_events [$];

  // decodes one packet against the lap table, returns 1 when an event follows
  function automatic bit decode_packet(input logic ok, input logic [ID_BITS-1:0] id,
                                       input logic [TS_BITS-1:0] ts, output result_t ev);
    int                 who;
    int                 kind;
    logic [TS_BITS-1:0] stamp;
    bit                 hit;
    stamp = ts & STAMP_MASK;
    who   = int'(id) % TRANSPONDERS;
    kind  = int'(id) / TRANSPONDERS;
    hit   = 1'b0;
    ev    = '0;
    ev.transponder = who[WHO_BITS-1:0];
    if (!ok) return 1'b0;
    if (kind == int'(KIND_LAP)) begin
      if (armed[who] && stamp_store[who] != stamp) begin
        ev.event_kind  = KIND_LAP;
        ev.event_value = VALUE_BITS'((stamp - stamp_store[who]) & STAMP_MASK);
        hit = 1'b1;
      end
      armed[who]       = 1'b1;
      stamp_store[who] = stamp;
    end else if (kind == int'(KIND_RETRY)) begin
      ev.event_kind  = KIND_RETRY;
      ev.event_value = VALUE_BITS'(stamp[RETRY_BITS-1:0]);
      hit = 1'b1;
    end else if (kind == int'(KIND_POWER)) begin
      ev.event_kind  = KIND_POWER;
      ev.event_value = '0;
      hit = 1'b1;
    end
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    result_t ev;
    result_t want;
    if (!rst_n) begin
      foreach (armed[i]) armed[i] = 1'b0;
      expected_events.delete();
      mismatch_count = 0;
      events_checked = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_packet(in_length_ok, in_packet_id, in_timestamp, ev))
          expected_events.push_back(ev);
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected event: kind %0d transponder %0d value %06h",
                     out_event_kind, out_transponder, out_event_value);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_event_kind !== want.event_kind || out_transponder !== want.transponder ||
              out_event_value !== want.event_value) begin
            if (mismatch_count < 10)
              $display("event %0d: expected kind %0d transponder %0d value %06h, got %0d %0d %06h",
                       events_checked, want.event_kind, want.transponder, want.event_value,
                       out_event_kind, out_transponder, out_event_value);
            mismatch_count++;
          end
          events_checked++;
        end
      end
    end
    pending = expected_events.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ltd_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_length_ok;
  logic [ID_BITS-1:0]    in_packet_id;
  logic [TS_BITS-1:0]    in_timestamp;
  logic                  out_valid;
  logic                  out_stall;
  logic [KIND_BITS-1:0]  out_event_kind;
  logic [WHO_BITS-1:0]   out_transponder;
  logic [VALUE_BITS-1:0] out_event_value;

  int mismatch_count;
  int pending;
  int events_checked;

  bit                 calm;
  int                 packets_sent;
  int                 packets_ignored;
  logic [TS_BITS-1:0] sent_stamp [TRANSPONDERS];

  lap_time_event_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_length_ok    (in_length_ok),
    .in_packet_id    (in_packet_id),
    .in_timestamp    (in_timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_transponder (out_transponder),
    .out_event_value (out_event_value)
  );

  lap_event_monitor mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_length_ok    (in_length_ok),
    .in_packet_id    (in_packet_id),
    .in_timestamp    (in_timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_transponder (out_transponder),
    .out_event_value (out_event_value),
    .mismatch_count  (mismatch_count),
    .pending         (pending),
    .events_checked  (events_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !calm && ($urandom_range(0, 99) < 8);
    end
  end

  // one packet beat, with an occasional gap in front of it
  task automatic send_packet(input bit ok, input int id, input logic [TS_BITS-1:0] ts);
    if (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_length_ok <= ok;
    in_packet_id <= id[ID_BITS-1:0];
    in_timestamp <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    packets_sent++;
    if (!ok || id / TRANSPONDERS > int'(KIND_POWER)) packets_ignored++;
    if (ok && id < TRANSPONDERS) sent_stamp[id] = ts;
  endtask

  function automatic logic [TS_BITS-1:0] lap_stamp(input int who);
    case ($urandom_range(0, 9))
      0: return sent_stamp[who];
      1: return sent_stamp[who] + TS_BITS'($urandom_range(1, 5000));
      2: return sent_stamp[who] - TS_BITS'($urandom_range(1, 5000));
      3: return $urandom_range(0, 1) ? '1 : '0;
      default: return TS_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int counted;
    int who;
    int pick;
    int guard;
    int failures;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_length_ok <= 1'b0;
    in_packet_id <= '0;
    in_timestamp <= '0;
    calm          = 1'b0;
    packets_sent  = 0;
    packets_ignored = 0;
    foreach (sent_stamp[i]) sent_stamp[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-up and retry reports at both ends of the transponder range
    send_packet(1, 2 * TRANSPONDERS, 24'h123456);
    send_packet(1, 3 * TRANSPONDERS - 1, '1);
    send_packet(1, TRANSPONDERS, '1);
    send_packet(1, 2 * TRANSPONDERS - 1, 24'h0000ab);
    // dropped packets give nothing, even for reporting kinds
    send_packet(0, TRANSPONDERS + 3, 24'h000077);
    send_packet(0, 5, 24'd100);
    // a dropped lap must not arm the transponder
    send_packet(1, 5, 24'd200);
    send_packet(1, 5, 24'd300);
    // first lap, backward wrap, repeated stamp, full-scale stamp
    send_packet(1, 0, 24'h000010);
    send_packet(1, 0, 24'h000005);
    send_packet(1, 0, 24'h000005);
    send_packet(1, 0, '1);
    send_packet(1, TRANSPONDERS - 1, '1);
    send_packet(1, TRANSPONDERS - 1, '0);
    // unknown kinds give nothing and leave the table alone
    send_packet(1, 3 * TRANSPONDERS, 24'h000001);
    send_packet(1, 255, '1);
    send_packet(1, 4 * TRANSPONDERS - 1, 24'h555555);
    send_packet(1, TRANSPONDERS - 1, 24'h000001);

    counted = 0;
    while (counted < 550) begin
      calm = (counted >= 200 && counted < 320);
      who  = $urandom_range(0, TRANSPONDERS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_packet(1, who, lap_stamp(who));
      end else if (pick < 68) begin
        send_packet(1, int'(KIND_RETRY) * TRANSPONDERS + who, TS_BITS'($urandom));
      end else if (pick < 78) begin
        send_packet(1, int'(KIND_POWER) * TRANSPONDERS + who, TS_BITS'($urandom));
      end else if (pick < 89) begin
        send_packet(1, $urandom_range(3 * TRANSPONDERS, 255), TS_BITS'($urandom));
      end else begin
        send_packet(0, $urandom_range(0, 255), TS_BITS'($urandom));
      end
      counted++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);

    failures = mismatch_count + pending;
    $display("%0d packets sent, %0d of them dropped or of unknown kind", packets_sent,
             packets_ignored);
    $display("%0d lap, retry and power-up events compared, %0d still missing",
             events_checked, pending);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
